[design/evm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// evm_pkg
// Constants and helpers for the Euler-angle view matrix pipeline.
// ----------------------------------------------------------------------------
package evm_pkg;

    localparam int MAX_ITER = 24;
    localparam logic signed [15:0] PI_Q13      = 16'sd25736;
    localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [32:0] GAIN_Q30    = 33'sd652032875;
    localparam logic signed [15:0] ONE_Q14     = 16'sd16384;

    // arctangent of 2^-i in Q.30
    function automatic logic signed [32:0] atan_q30(input int idx);
        logic signed [32:0] r;
        begin
            case (idx)
                0:  r = 33'sd843314857;
                1:  r = 33'sd497837830;
                2:  r = 33'sd263043837;
                3:  r = 33'sd133525159;
                4:  r = 33'sd67021687;
                5:  r = 33'sd33543516;
                6:  r = 33'sd16775851;
                7:  r = 33'sd8388437;
                8:  r = 33'sd4194283;
                9:  r = 33'sd2097149;
                default: r = 33'sd1 <<< (30 - idx);
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

[design/euler_view_matrix_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// euler_view_matrix_core
// Throughput: one pose per clock while the output is not stalled; an unrolled
// CORDIC stage per iteration, then products, entry rounding, translation
// multiply and sum stages.
// A stall freezes the whole pipeline; no word is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module euler_view_matrix_core
    import evm_pkg::*;
#(
    parameter int TRIG_ITERATIONS = 14
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] roll_angle,
    input  wire logic signed [15:0] pitch_angle,
    input  wire logic signed [15:0] yaw_angle,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      m_r0c0,
    output logic signed [15:0]      m_r0c1,
    output logic signed [15:0]      m_r0c2,
    output logic signed [15:0]      m_r1c0,
    output logic signed [15:0]      m_r1c1,
    output logic signed [15:0]      m_r1c2,
    output logic signed [15:0]      m_r2c0,
    output logic signed [15:0]      m_r2c1,
    output logic signed [15:0]      m_r2c2,
    output logic signed [31:0]      trans_x,
    output logic signed [31:0]      trans_y,
    output logic signed [31:0]      trans_z
);

    localparam int N = TRIG_ITERATIONS;
    // stage count: reduce, N cordic, round, prod2, prod3, entry, tmul, tsum
    localparam int NST = N + 7;

    typedef logic signed [34:0] cw_t;   // cordic x/y/z width
    typedef logic signed [31:0] pos_t;

    logic adv;
    logic [NST-1:0] v_reg;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;
    assign out_valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[NST-2:0], in_valid};
    end

    // ---- position delay line through the trig and product stages
    pos_t px_reg [N+5];
    pos_t py_reg [N+5];
    pos_t pz_reg [N+5];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg[0] <= pos_x;
            py_reg[0] <= pos_y;
            pz_reg[0] <= pos_z;
            for (int k = 1; k < N + 5; k++)
            begin
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
                pz_reg[k] <= pz_reg[k-1];
            end
        end
    end

    // ---- angle reduction (stage 0) and CORDIC (stages 1..N), three lanes
    cw_t x_reg [3][N+1];
    cw_t y_reg [3][N+1];
    cw_t z_reg [3][N+1];
    logic flip_reg [3][N+1];
    logic signed [15:0] ang [3];
    assign ang[0] = roll_angle;
    assign ang[1] = pitch_angle;
    assign ang[2] = yaw_angle;

    logic signed [15:0] s_reg [3];
    logic signed [15:0] c_reg [3];

    function automatic logic signed [15:0] rnd16(input cw_t v, input logic f);
        cw_t t;
        cw_t r;
        begin
            t = f ? -v : v;
            r = (t + 35'sd32768) >>> 16;
            if (r > 35'sd16384)       return ONE_Q14;
            else if (r < -35'sd16384) return -ONE_Q14;
            else                      return r[15:0];
        end
    endfunction

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic signed [16:0] a_red;
        logic flip;
        always_comb
        begin
            flip  = 1'b0;
            a_red = 17'(ang[l]);
            if (ang[l] > HALF_PI_Q13)
            begin
                a_red = 17'(ang[l]) - 17'(PI_Q13);
                flip  = 1'b1;
            end
            else if (ang[l] < -HALF_PI_Q13)
            begin
                a_red = 17'(ang[l]) + 17'(PI_Q13);
                flip  = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[l][0]    <= 35'(GAIN_Q30);
                y_reg[l][0]    <= '0;
                z_reg[l][0]    <= 35'(a_red) <<< 17;
                flip_reg[l][0] <= flip;
            end
        end

        for (genvar i = 0; i < N; i++)
        begin : g_it
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    flip_reg[l][i+1] <= flip_reg[l][i];
                    if (!z_reg[l][i][34])
                    begin
                        x_reg[l][i+1] <= x_reg[l][i] - (y_reg[l][i] >>> i);
                        y_reg[l][i+1] <= y_reg[l][i] + (x_reg[l][i] >>> i);
                        z_reg[l][i+1] <= z_reg[l][i] - 35'(atan_q30(i));
                    end
                    else
                    begin
                        x_reg[l][i+1] <= x_reg[l][i] + (y_reg[l][i] >>> i);
                        y_reg[l][i+1] <= y_reg[l][i] - (x_reg[l][i] >>> i);
                        z_reg[l][i+1] <= z_reg[l][i] + 35'(atan_q30(i));
                    end
                end
            end
        end

        // stage N+1: round to Q1.14
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                s_reg[l] <= rnd16(y_reg[l][N], flip_reg[l][N]);
                c_reg[l] <= rnd16(x_reg[l][N], flip_reg[l][N]);
            end
        end
    end

    // ---- stage N+2: two-factor products (Q.28), carry singles
    logic signed [31:0] crcy_reg, srcy_reg, crsy_reg, srsy_reg, cpsy_reg, cpcy_reg;
    logic signed [31:0] srcp_reg, crcp_reg, sp28_reg;
    logic signed [15:0] sr2_reg, cr2_reg;
    logic signed [31:0] spsy_reg, spcy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            crcy_reg <= c_reg[0] * c_reg[2];
            srcy_reg <= s_reg[0] * c_reg[2];
            crsy_reg <= c_reg[0] * s_reg[2];
            srsy_reg <= s_reg[0] * s_reg[2];
            cpsy_reg <= c_reg[1] * s_reg[2];
            cpcy_reg <= c_reg[1] * c_reg[2];
            srcp_reg <= s_reg[0] * c_reg[1];
            crcp_reg <= c_reg[0] * c_reg[1];
            spsy_reg <= s_reg[1] * s_reg[2];
            spcy_reg <= s_reg[1] * c_reg[2];
            sp28_reg <= 32'(s_reg[1]) <<< 14;
            sr2_reg  <= s_reg[0];
            cr2_reg  <= c_reg[0];
        end
    end

    // ---- stage N+3: Q.42 entries
    typedef logic signed [47:0] e_t;
    e_t e_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_reg[0] <= (48'(crcy_reg) <<< 14) - sr2_reg * spsy_reg;
            e_reg[1] <= -(48'(srcp_reg) <<< 14);
            e_reg[2] <= (48'(crsy_reg) <<< 14) + sr2_reg * spcy_reg;
            e_reg[3] <= (48'(srcy_reg) <<< 14) + cr2_reg * spsy_reg;
            e_reg[4] <= 48'(crcp_reg) <<< 14;
            e_reg[5] <= (48'(srsy_reg) <<< 14) - cr2_reg * spcy_reg;
            e_reg[6] <= -(48'(cpsy_reg) <<< 14);
            e_reg[7] <= 48'(sp28_reg) <<< 14;
            e_reg[8] <= 48'(cpcy_reg) <<< 14;
        end
    end

    // ---- stage N+4: round entries
    logic signed [15:0] m_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                automatic e_t r = (e_reg[k] + 48'sd134217728) >>> 28;
                if (r > 48'sd16384)       m_reg[k] <= ONE_Q14;
                else if (r < -48'sd16384) m_reg[k] <= -ONE_Q14;
                else                      m_reg[k] <= r[15:0];
            end
        end
    end

    // ---- stage N+5: entry times position
    logic signed [47:0] tp_reg [9];
    logic signed [15:0] m2_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                tp_reg[r*3]   <= m_reg[r*3]   * px_reg[N+4];
                tp_reg[r*3+1] <= m_reg[r*3+1] * py_reg[N+4];
                tp_reg[r*3+2] <= m_reg[r*3+2] * pz_reg[N+4];
            end
            m2_reg <= m_reg;
        end
    end

    // ---- stage N+6: sum, round, saturate
    logic signed [31:0] t_reg [3];
    logic signed [15:0] m3_reg [9];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                automatic logic signed [49:0] acc = 50'(tp_reg[r*3]) + 50'(tp_reg[r*3+1])
                                                  + 50'(tp_reg[r*3+2]) + 50'sd8192;
                automatic logic signed [49:0] q = acc >>> 14;
                if (q > 50'sd2147483647)       t_reg[r] <= 32'h7fffffff;
                else if (q < -50'sd2147483648) t_reg[r] <= 32'h80000000;
                else                           t_reg[r] <= q[31:0];
            end
            m3_reg <= m2_reg;
        end
    end

    assign m_r0c0 = m3_reg[0];
    assign m_r0c1 = m3_reg[1];
    assign m_r0c2 = m3_reg[2];
    assign m_r1c0 = m3_reg[3];
    assign m_r1c1 = m3_reg[4];
    assign m_r1c2 = m3_reg[5];
    assign m_r2c0 = m3_reg[6];
    assign m_r2c1 = m3_reg[7];
    assign m_r2c2 = m3_reg[8];
    assign trans_x = t_reg[0];
    assign trans_y = t_reg[1];
    assign trans_z = t_reg[2];

    // a stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(trans_x) && $stable(m_r1c1))
        else $error("output word changed under stall");
    // entries stay in range
    a_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (m_r2c1 <= ONE_Q14) && (m_r2c1 >= -ONE_Q14))
        else $error("entry out of range");
    // input stall only while output is stalled
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("spurious input stall");

endmodule
`default_nettype wire

[sim/euler_view_matrix_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_view_matrix_core_test
// Drives random and corner-case camera poses into the view matrix core and
// checks every output word against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module euler_view_matrix_core_test;
    import evm_pkg::*;

    localparam int ITERS = 14;
    localparam int LATENCY = ITERS + 7;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [15:0] m [9];
        logic signed [31:0] t [3];
    } pose_matrix_t;

    class matrix_scoreboard;
        pose_matrix_t pending[$];
        int errors = 0;
        int checked = 0;

        function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function longint clampv(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void sin_cos(logic signed [15:0] ang, output longint s, output longint c);
            longint a, x, y, z, dx, dy;
            bit flip;
            a = ang;
            flip = 0;
            if (a > HALF_PI_Q13) begin a -= PI_Q13; flip = 1; end
            else if (a < -HALF_PI_Q13) begin a += PI_Q13; flip = 1; end
            x = 652032875; y = 0; z = a * 131072;
            for (int i = 0; i < ITERS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin x -= dx; y += dy; z -= atan_tab(i); end
                else begin x += dx; y -= dy; z += atan_tab(i); end
            end
            if (flip) begin x = -x; y = -y; end
            c = clampv((x + 32768) >>> 16, -16384, 16384);
            s = clampv((y + 32768) >>> 16, -16384, 16384);
        endfunction

        function longint atan_tab(int i);
            longint t [10] = '{843314857, 497837830, 263043837, 133525159, 67021687,
                               33543516, 16775851, 8388437, 4194283, 2097149};
            if (i < 10) return t[i];
            return longint'(1) << (30 - i);
        endfunction

        function longint round_entry(longint v);
            return clampv((v + (longint'(1) << 27)) >>> 28, -16384, 16384);
        endfunction

        function void note_pose(logic signed [15:0] r, logic signed [15:0] p,
                                logic signed [15:0] yw, logic signed [31:0] px,
                                logic signed [31:0] py, logic signed [31:0] pz);
            longint sr, cr, sp, cp, sy, cy, acc;
            longint m [9];
            longint pv [3];
            pose_matrix_t e;
            sin_cos(r, sr, cr);
            sin_cos(p, sp, cp);
            sin_cos(yw, sy, cy);
            pv[0] = px; pv[1] = py; pv[2] = pz;
            m[0] = round_entry(cr * cy * 16384 - sr * sp * sy);
            m[1] = round_entry(-sr * cp * 16384);
            m[2] = round_entry(cr * sy * 16384 + sr * sp * cy);
            m[3] = round_entry(sr * cy * 16384 + cr * sp * sy);
            m[4] = round_entry(cr * cp * 16384);
            m[5] = round_entry(sr * sy * 16384 - cr * sp * cy);
            m[6] = round_entry(-cp * sy * 16384);
            m[7] = round_entry(sp * 16384 * 16384);
            m[8] = round_entry(cp * cy * 16384);
            for (int k = 0; k < 9; k++) e.m[k] = m[k][15:0];
            for (int rr = 0; rr < 3; rr++)
            begin
                acc = m[rr*3] * pv[0] + m[rr*3+1] * pv[1] + m[rr*3+2] * pv[2];
                e.t[rr] = 32'(clampv((acc + 8192) >>> 14, -64'sd2147483648,
                                     64'sd2147483647));
            end
            pending.push_back(e);
        endfunction

        function void check_word(pose_matrix_t got);
            pose_matrix_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected output word", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            for (int k = 0; k < 9; k++)
                if (got.m[k] !== e.m[k])
                begin
                    $display("%0t: entry %0d expected %0d actual %0d", $time, k,
                             e.m[k], got.m[k]);
                    errors++;
                end
            for (int k = 0; k < 3; k++)
                if (got.t[k] !== e.t[k])
                begin
                    $display("%0t: trans %0d expected %0d actual %0d", $time, k,
                             e.t[k], got.t[k]);
                    errors++;
                end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic out_stall = 0;
    logic signed [15:0] roll_angle = 0, pitch_angle = 0, yaw_angle = 0;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
    wire in_stall, out_valid;
    wire signed [15:0] m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2;
    wire signed [15:0] m_r2c0, m_r2c1, m_r2c2;
    wire signed [31:0] trans_x, trans_y, trans_z;

    matrix_scoreboard board = new();
    int send_idle = 0;
    int recv_stall = 0;
    longint cycles = 0;
    int sent = 0;

    euler_view_matrix_core #(.TRIG_ITERATIONS(ITERS)) dut (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        pose_matrix_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        if (rst_n && in_valid && !in_stall)
            board.note_pose(roll_angle, pitch_angle, yaw_angle, pos_x, pos_y, pos_z);
        if (rst_n && out_valid && !out_stall)
        begin
            got.m = '{m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                      m_r2c0, m_r2c1, m_r2c2};
            got.t = '{trans_x, trans_y, trans_z};
            board.check_word(got);
        end
    end

    // receiver stall pattern, updated on the falling edge
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall);

    function automatic logic signed [15:0] pick_angle();
        case ($urandom_range(5))
            0: return 16'(int'($urandom_range(51472)) - 25736);
            1: return 16'($urandom);
            2: return 16'(int'($urandom_range(8)) + 12864);
            3: return 16'(int'($urandom_range(8)) - 12872);
            default: return 16'(int'($urandom_range(51472)) - 25736);
        endcase
    endfunction

    function automatic logic signed [31:0] pick_pos();
        case ($urandom_range(3))
            0: return 32'($urandom);
            1: return 32'(int'($urandom_range(2000000)) - 1000000);
            2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return 32'($urandom) >>> $urandom_range(20);
        endcase
    endfunction

    // valid stays high after a word so back-to-back words need no gap
    task automatic send_pose(logic signed [15:0] r, logic signed [15:0] p,
                             logic signed [15:0] yw, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] pz);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        roll_angle <= r; pitch_angle <= p; yaw_angle <= yw;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic random_poses(int n, int idle, int stall);
        send_idle = idle;
        recv_stall = stall;
        for (int i = 0; i < n; i++)
            send_pose(pick_angle(), pick_angle(), pick_angle(),
                      pick_pos(), pick_pos(), pick_pos());
    endtask

    task automatic wait_drained();
        in_valid <= 0;
        @(negedge clk);
        while (board.pending.size() != 0) @(negedge clk);
    endtask

    initial
    begin
        logic signed [15:0] corner [8] = '{16'sd0, 16'sd25736, -16'sd25736,
            16'sd12868, -16'sd12868, 16'sd12869, -16'sd12869, 16'sd6434};
        repeat (3) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // directed corners: angle extremes, reduction boundaries, extreme positions
        for (int i = 0; i < 8; i++)
            send_pose(corner[i], corner[(i + 3) % 8], corner[(i + 5) % 8],
                      32'sh7fffffff, 32'sh80000000, 32'sh00010000);
        send_pose(16'sh7fff, 16'sh8000, 16'sh7fff, 32'sh80000000, 32'sh80000000,
                  32'sh80000000);
        send_pose(16'sh8000, 16'sh7fff, 16'sh8000, 32'sh7fffffff, 32'sh7fffffff,
                  32'sh7fffffff);
        send_pose(16'sh5555, 16'shaaaa, 16'sh0fff, 32'shffffffff, 32'h55555555,
                  32'shaaaaaaaa);
        send_pose(0, 0, 0, 0, 0, 0);
        random_poses(400, 0, 0);
        // hold off until the pipeline has emptied
        wait_drained();
        random_poses(450, 78, 0);
        random_poses(450, 0, 78);
        random_poses(450, 23, 23);
        wait_drained();
        recv_stall = 0;
        repeat (LATENCY + 5) @(negedge clk);
        $display("Sent %0d poses, checked %0d matrices over four idle/stall phases.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[files.f]
design/evm_pkg.sv
design/euler_view_matrix_core.sv
sim/euler_view_matrix_core_test.sv
